### src/wdp_pkg.sv
// Shared types and constants for the waypoint distance PID block.
// No dependencies; every other file imports this package.
package wdp_pkg;

  // Fixed widths of the configuration port.
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Step counts of the serial root and divide unit.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;

  // Register reset values.
  localparam logic [23:0] RST_GAIN_P    = 24'd55706;
  localparam logic [23:0] RST_GAIN_I    = 24'd16384;
  localparam logic [23:0] RST_GAIN_D    = 24'd9830;
  localparam logic [23:0] RST_INT_LIMIT = 24'd39322;
  localparam logic [15:0] RST_INT_DECAY = 16'd62259;
  localparam logic [23:0] RST_SPEED_LIM = 24'd39322;
  localparam logic [23:0] RST_ARRIVE    = 24'd2621;
  localparam logic [23:0] RST_SPACING   = 24'd65536;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        dt;
  } in_word_t;

  typedef struct packed {
    logic signed [24:0] speed;
    logic [1:0]         cause;
  } out_word_t;

  typedef enum logic [1:0] {
    CAUSE_DRIVE = 2'd0,
    CAUSE_NEAR  = 2'd1,
    CAUSE_FAIL  = 2'd2
  } cause_t;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_INT_DECAY = 3'd4,
    REG_SPEED_LIM = 3'd5,
    REG_ARRIVE    = 3'd6,
    REG_SPACING   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
    logic [23:0] integral_limit;
    logic [15:0] integral_decay;
    logic [23:0] speed_limit;
    logic [23:0] arrive_tolerance;
    logic [23:0] setpoint_spacing;
  } cfg_regs_t;

  typedef enum logic {
    ITER_SQRT = 1'b0,
    ITER_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [63:0] opa;
    logic [23:0] opb;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } iter_rsp_t;

  // Magnitude operands after scaling below 2^31.
  typedef struct packed {
    logic [30:0] a;
    logic [30:0] b;
    logic [1:0]  s;
  } mag_ld_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_SUM,
    ST_ROOT,
    ST_ARRIVE,
    ST_SPX,
    ST_TG_LOAD,
    ST_ERR,
    ST_INT_A,
    ST_INT_B,
    ST_INT_C,
    ST_INT_D,
    ST_P,
    ST_I,
    ST_D,
    ST_DIV,
    ST_SUM,
    ST_EMIT
  } wdp_state_t;

endpackage

### src/wdp_cfg.sv
// Configuration register file of the waypoint distance PID block.
// Depends on wdp_pkg for the register index codes and the register struct.
module wdp_cfg import wdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r;

  // Write one register per enabled cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.gain_p           <= RST_GAIN_P;
      regs_r.gain_i           <= RST_GAIN_I;
      regs_r.gain_d           <= RST_GAIN_D;
      regs_r.integral_limit   <= RST_INT_LIMIT;
      regs_r.integral_decay   <= RST_INT_DECAY;
      regs_r.speed_limit      <= RST_SPEED_LIM;
      regs_r.arrive_tolerance <= RST_ARRIVE;
      regs_r.setpoint_spacing <= RST_SPACING;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:    regs_r.gain_p           <= cfg_wdata;
        REG_GAIN_I:    regs_r.gain_i           <= cfg_wdata;
        REG_GAIN_D:    regs_r.gain_d           <= cfg_wdata;
        REG_INT_LIMIT: regs_r.integral_limit   <= cfg_wdata;
        REG_INT_DECAY: regs_r.integral_decay   <= cfg_wdata[15:0];
        REG_SPEED_LIM: regs_r.speed_limit      <= cfg_wdata;
        REG_ARRIVE:    regs_r.arrive_tolerance <= cfg_wdata;
        REG_SPACING:   regs_r.setpoint_spacing <= cfg_wdata;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

### src/wdp_iter.sv
// Shared serial unit: floor square root of a 64-bit value (two bits a step)
// and unsigned 64 by 24 bit divide (one bit a step). Depends on wdp_pkg.
module wdp_iter import wdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  iter_op_t    op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [32:0] root_r, root_nxt;
  logic [23:0] div_r, div_nxt;

  logic [35:0] cmp_a, cmp_b, diff;
  logic        ge;

  // One shared compare and subtract serves both operations.
  always_comb begin
    if (op_r == ITER_SQRT) begin
      cmp_a = {rem_r[33:0], acc_r[63:62]};
      cmp_b = {1'b0, root_r, 2'b01};
    end else begin
      cmp_a = {rem_r[34:0], acc_r[63]};
      cmp_b = {12'b0, div_r};
    end
    ge   = (cmp_a >= cmp_b);
    diff = cmp_a - cmp_b;
  end

  // Step sequencing.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    div_nxt  = div_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = (req.op == ITER_SQRT) ? 7'(SQRT_STEPS) : 7'(DIV_STEPS);
      acc_nxt  = req.opa;
      rem_nxt  = '0;
      root_nxt = '0;
      div_nxt  = req.opb;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : cmp_a;
      if (op_r == ITER_SQRT) begin
        root_nxt = {root_r[31:0], ge};
        acc_nxt  = {acc_r[61:0], 2'b00};
      end else begin
        acc_nxt = {acc_r[62:0], ge};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ITER_SQRT;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = (op_r == ITER_SQRT) ? {31'b0, root_r} : acc_r;

endmodule

### src/waypoint_distance_pid_top.sv
// Top level of the waypoint distance PID block: sequencer, shared multiplier
// and state. Depends on wdp_pkg, wdp_cfg and wdp_iter.
//
//  Port group | Direction | Handshake         | Word
//  in_*       | input     | in_valid/in_ready | pos_x, pos_y, dt
//  out_*      | output    | out_valid/out_ready | speed, cause
//  cfg_*      | input     | cfg_we            | cfg_index, cfg_wdata
//
// A drive sample runs the motion root, the distance root and error decision,
// the PID terms, a divide and the emit step; a stop skips the PID terms and
// divide, priming or arrival ends at the error decision, a latched failure or
// the final setpoint after the motion root; in_ready returns the next cycle.
// Reset is synchronous; a waiting output word does not hold off the next
// sample, but a second result stalls the emit step until the register frees.
module waypoint_distance_pid_top import wdp_pkg::*; #(
  parameter int NUM_SETPOINTS = 3,
  parameter int FRAC_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (NUM_SETPOINTS > 1) ? $clog2(NUM_SETPOINTS) : 1;
  localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(NUM_SETPOINTS - 1);
  localparam logic signed [33:0] RISE_LIMIT = 34'((64'd1 << FRAC_BITS) / 100);

  cfg_regs_t cfg;
  iter_req_t iter_req;
  iter_rsp_t iter_rsp;

  wdp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (cfg)
  );

  wdp_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

  wdp_state_t state_r, state_nxt;

  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic [23:0]        dt_r, dt_nxt;
  logic signed [31:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [31:0] prev_err_r, prev_err_nxt, integ_r, integ_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               priming_r, priming_nxt, arrived_r, arrived_nxt;
  logic               failed_r, failed_nxt;
  mag_ld_t            mag_r, mag_nxt;
  logic               tgt_phase_r, tgt_phase_nxt, tgt_neg_r, tgt_neg_nxt;
  logic [62:0]        sq_a_r, sq_a_nxt;
  logic               still_r, still_nxt;
  logic signed [31:0] err_r, err_nxt, iclamp_r, iclamp_nxt, ii_r, ii_nxt;
  logic signed [63:0] pterm_r, pterm_nxt, iterm_r, iterm_nxt, dterm_r, dterm_nxt;
  logic               dneg_r, dneg_nxt;
  logic signed [24:0] res_speed_r, res_speed_nxt;
  cause_t             res_cause_r, res_cause_nxt;
  logic signed [63:0] prod_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  // Shared multiplier operands and registered product.
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] mul_full;

  // Scratch values of the sequencer.
  logic signed [33:0] dx_m, dy_m, dx_t, dy_t;
  logic [34:0]        root_len;
  logic [41:0]        dist100;
  logic [32:0]        abs_e, abs_pe;
  logic signed [33:0] rise;
  logic signed [63:0] isum, isat, prod_sh, ii_full, usum, uclamp, spd_lim;
  logic [63:0]        div_mag;

  // Scale two signed components so that both magnitudes fall below 2^31.
  function automatic mag_ld_t mag_load(input logic signed [33:0] a,
                                       input logic signed [33:0] b);
    logic [33:0] ua, ub, uo;
    mag_ld_t     r;
    ua = a[33] ? 34'(-a) : 34'(a);
    ub = b[33] ? 34'(-b) : 34'(b);
    uo = ua | ub;
    if (uo[33]) begin
      r.s = 2'd3;
    end else if (uo[32]) begin
      r.s = 2'd2;
    end else if (uo[31]) begin
      r.s = 2'd1;
    end else begin
      r.s = 2'd0;
    end
    r.a = 31'(ua >> r.s);
    r.b = 31'(ub >> r.s);
    return r;
  endfunction

  assign mul_full = mul_a * mul_b;

  // Multiplier operand selection per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SPX: begin
        mul_a = 34'({1'b0, idx_r} + (IDX_W+1)'(1));
        mul_b = 32'(cfg.setpoint_spacing);
      end
      ST_SQ_A: begin
        mul_a = 34'(mag_r.a);
        mul_b = 32'(mag_r.a);
      end
      ST_SQ_B: begin
        mul_a = 34'(mag_r.b);
        mul_b = 32'(mag_r.b);
      end
      ST_INT_A: begin
        mul_a = 34'(err_r);
        mul_b = 32'(dt_r);
      end
      ST_INT_C: begin
        mul_a = 34'(iclamp_r);
        mul_b = 32'(cfg.integral_decay);
      end
      ST_INT_D: begin
        mul_a = 34'(err_r);
        mul_b = 32'(cfg.gain_p);
      end
      ST_P: begin
        mul_a = 34'(ii_r);
        mul_b = 32'(cfg.gain_i);
      end
      ST_I: begin
        mul_a = 34'(err_r) - 34'(prev_err_r);
        mul_b = 32'(cfg.gain_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Fixed scratch arithmetic.
  always_comb begin
    dx_m     = 34'(in_data.pos_x) - 34'(prev_x_r);
    dy_m     = 34'(in_data.pos_y) - 34'(prev_y_r);
    dx_t     = prod_r[33:0] - 34'(px_r);
    dy_t     = -34'(py_r);
    root_len = {3'b0, iter_rsp.result[31:0]} << mag_r.s;
    dist100  = {1'b0, root_len, 6'b0} + {2'b0, root_len, 5'b0} + {5'b0, root_len, 2'b0};
    abs_e    = err_r[31] ? 33'(-34'(err_r)) : 33'(err_r);
    abs_pe   = prev_err_r[31] ? 33'(-34'(prev_err_r)) : 33'(prev_err_r);
    rise     = $signed({1'b0, abs_e}) - $signed({1'b0, abs_pe});
    prod_sh  = prod_r >>> FRAC_BITS;
    isum     = 64'(integ_r) + prod_sh;
    if (isum > 64'sh7FFF_FFFF) begin
      isat = 64'sh7FFF_FFFF;
    end else if (isum < -64'sh8000_0000) begin
      isat = -64'sh8000_0000;
    end else begin
      isat = isum;
    end
    ii_full = prod_r >>> 16;
    div_mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    spd_lim = 64'(cfg.speed_limit);
    usum    = pterm_r + iterm_r + dterm_r;
    if (usum > spd_lim) begin
      uclamp = spd_lim;
    end else if (usum < -spd_lim) begin
      uclamp = -spd_lim;
    end else begin
      uclamp = usum;
    end
  end

  // Sequencer: next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    dt_nxt        = dt_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_err_nxt  = prev_err_r;
    integ_nxt     = integ_r;
    idx_nxt       = idx_r;
    priming_nxt   = priming_r;
    arrived_nxt   = arrived_r;
    failed_nxt    = failed_r;
    mag_nxt       = mag_r;
    tgt_phase_nxt = tgt_phase_r;
    tgt_neg_nxt   = tgt_neg_r;
    sq_a_nxt      = sq_a_r;
    still_nxt     = still_r;
    err_nxt       = err_r;
    iclamp_nxt    = iclamp_r;
    ii_nxt        = ii_r;
    pterm_nxt     = pterm_r;
    iterm_nxt     = iterm_r;
    dterm_nxt     = dterm_r;
    dneg_nxt      = dneg_r;
    res_speed_nxt = res_speed_r;
    res_cause_nxt = res_cause_r;
    iter_req      = '0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = (state_r == ST_IDLE);

    // The output register drains independently of the sequencer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          px_nxt        = in_data.pos_x;
          py_nxt        = in_data.pos_y;
          dt_nxt        = in_data.dt;
          mag_nxt       = mag_load(dx_m, dy_m);
          tgt_phase_nxt = 1'b0;
          state_nxt     = ST_SQ_A;
        end
      end
      ST_SQ_A: state_nxt = ST_SQ_B;
      ST_SQ_B: begin
        sq_a_nxt  = prod_r[62:0];
        state_nxt = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        iter_req.start = 1'b1;
        iter_req.op    = ITER_SQRT;
        iter_req.opa   = 64'(sq_a_r) + 64'(prod_r[62:0]);
        state_nxt      = ST_ROOT;
      end
      ST_ROOT: begin
        if (iter_rsp.done) begin
          if (!tgt_phase_r) begin
            still_nxt = (dist100 < 42'(dt_r));
            state_nxt = ST_ARRIVE;
          end else begin
            if (tgt_neg_r) begin
              err_nxt = (root_len > 35'h0_8000_0000) ? 32'sh8000_0000
                                                     : 32'(~root_len[31:0] + 32'd1);
            end else begin
              err_nxt = (root_len > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                     : $signed(root_len[31:0]);
            end
            state_nxt = ST_ERR;
          end
        end
      end
      ST_ARRIVE: begin
        if (arrived_r && ({1'b0, idx_r} >= LAST_IDX)) begin
          // Final setpoint reached: the sample leaves no trace.
          state_nxt = ST_IDLE;
        end else begin
          if (arrived_r) begin
            idx_nxt     = idx_r + IDX_W'(1);
            priming_nxt = 1'b1;
            arrived_nxt = 1'b0;
          end
          if (failed_r) begin
            prev_x_nxt = px_r;
            prev_y_nxt = py_r;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_SPX;
          end
        end
      end
      ST_SPX: state_nxt = ST_TG_LOAD;
      ST_TG_LOAD: begin
        mag_nxt       = mag_load(dx_t, dy_t);
        tgt_neg_nxt   = dx_t[33];
        tgt_phase_nxt = 1'b1;
        state_nxt     = ST_SQ_A;
      end
      ST_ERR: begin
        prev_x_nxt = px_r;
        prev_y_nxt = py_r;
        priority if (priming_r) begin
          prev_err_nxt = err_r;
          priming_nxt  = 1'b0;
          integ_nxt    = '0;
          state_nxt    = ST_IDLE;
        end else if (abs_e < 33'(cfg.arrive_tolerance)) begin
          if (!still_r) begin
            res_speed_nxt = '0;
            res_cause_nxt = CAUSE_NEAR;
            state_nxt     = ST_EMIT;
          end else begin
            arrived_nxt = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (rise > RISE_LIMIT) begin
          failed_nxt    = 1'b1;
          res_speed_nxt = '0;
          res_cause_nxt = CAUSE_FAIL;
          state_nxt     = ST_EMIT;
        end else begin
          state_nxt = ST_INT_A;
        end
      end
      ST_INT_A: state_nxt = ST_INT_B;
      ST_INT_B: begin
        // Saturated integral, clamped from above.
        iclamp_nxt = (isat > $signed({40'b0, cfg.integral_limit}))
                     ? 32'(cfg.integral_limit) : isat[31:0];
        state_nxt  = ST_INT_C;
      end
      ST_INT_C: state_nxt = ST_INT_D;
      ST_INT_D: begin
        ii_nxt    = ii_full[31:0];
        state_nxt = ST_P;
      end
      ST_P: begin
        pterm_nxt = prod_sh;
        state_nxt = ST_I;
      end
      ST_I: begin
        iterm_nxt = prod_sh;
        state_nxt = ST_D;
      end
      ST_D: begin
        iter_req.start = 1'b1;
        iter_req.op    = ITER_DIV;
        iter_req.opa   = div_mag;
        iter_req.opb   = dt_r;
        dneg_nxt       = prod_r[63];
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (iter_rsp.done) begin
          if (dt_r == '0) begin
            dterm_nxt = '0;
          end else if (dneg_r) begin
            dterm_nxt = -$signed(iter_rsp.result);
          end else begin
            dterm_nxt = $signed(iter_rsp.result);
          end
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        res_speed_nxt = uclamp[24:0];
        res_cause_nxt = CAUSE_DRIVE;
        integ_nxt     = ii_r;
        prev_err_nxt  = err_r;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.speed = res_speed_r;
          out_data_nxt.cause = res_cause_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_err_r  <= '0;
      integ_r     <= '0;
      idx_r       <= '0;
      priming_r   <= 1'b1;
      arrived_r   <= 1'b0;
      failed_r    <= 1'b0;
      tgt_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_err_r  <= prev_err_nxt;
      integ_r     <= integ_nxt;
      idx_r       <= idx_nxt;
      priming_r   <= priming_nxt;
      arrived_r   <= arrived_nxt;
      failed_r    <= failed_nxt;
      tgt_phase_r <= tgt_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    dt_r        <= dt_nxt;
    mag_r       <= mag_nxt;
    tgt_neg_r   <= tgt_neg_nxt;
    sq_a_r      <= sq_a_nxt;
    still_r     <= still_nxt;
    err_r       <= err_nxt;
    iclamp_r    <= iclamp_nxt;
    ii_r        <= ii_nxt;
    pterm_r     <= pterm_nxt;
    iterm_r     <= iterm_nxt;
    dterm_r     <= dterm_nxt;
    dneg_r      <= dneg_nxt;
    res_speed_r <= res_speed_nxt;
    res_cause_r <= res_cause_nxt;
    prod_r      <= mul_full[63:0];
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Stop words always carry zero speed.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.cause != CAUSE_DRIVE) |-> out_data_r.speed == '0)
    else $error("stop word with nonzero speed");

  // The setpoint index never runs past the last setpoint.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} <= LAST_IDX)
    else $error("setpoint index out of range");

  // The shared unit finishes only while the sequencer waits for it.
  a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
    iter_rsp.done |-> (state_r == ST_ROOT || state_r == ST_DIV))
    else $error("serial unit result not awaited");

  // Failure is latched until reset.
  a_fail_latch: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag cleared");
`endif

endmodule
